[rtl/jdme_pkg.sv]
// Shared constants, types and the power-of-two table for the joystick drive mixer.
package jdme_pkg;

  localparam int STICK_W = 8;
  localparam int SCALE_W = 9;
  localparam int SHAPED_W = 12;
  localparam int VEL_W = 13;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [SCALE_W-1:0] CURVE_MAX = 9'd320;
  localparam logic [31:0] LOG2_K = 32'd24202;
  localparam logic [18:0] RECIP_127 = 19'd264208;
  localparam logic signed [VEL_W:0] OUT_LIMIT = 14'sd4064;

  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_SIGN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_CURVE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_CURVE = 2'd3;

  typedef enum logic [1:0] {
    MODE_ARCADE = 2'd0,
    MODE_TANK = 2'd1,
    MODE_REV_ARCADE = 2'd2,
    MODE_CURVATURE = 2'd3
  } drive_mode_t;

  // 2^(-i/16) in Q15
  function automatic logic [15:0] pow2_val(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd32768;
      5'd1: v = 16'd31379;
      5'd2: v = 16'd30048;
      5'd3: v = 16'd28774;
      5'd4: v = 16'd27554;
      5'd5: v = 16'd26386;
      5'd6: v = 16'd25268;
      5'd7: v = 16'd24197;
      5'd8: v = 16'd23170;
      5'd9: v = 16'd22188;
      5'd10: v = 16'd21247;
      5'd11: v = 16'd20346;
      5'd12: v = 16'd19484;
      5'd13: v = 16'd18658;
      5'd14: v = 16'd17867;
      5'd15: v = 16'd17109;
      5'd16: v = 16'd16384;
      default: v = 16'd16384;
    endcase
    return v;
  endfunction

endpackage

[rtl/joystick_drive_mixer_expo_top.sv]
// Top level of the joystick drive mixer: stick routing, two curve pipes, mixing and output.
//
// Usage:
//   Input beats on in_tvalid/in_tready carry one sample of four stick axes in in_tdata.
//   Output beats on out_tvalid/out_tready carry the left and right wheel commands, signed
//   with 4 fractional bits, saturated to +/-4064. Every input beat gives one output beat,
//   in order.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while the block is idle:
//   index 0 drive mode, 1 throttle sign, 2 throttle curve, 3 turn curve. Curve values above
//   320 are clamped on write; a sign of -2 is stored as -1.
//   Each input beat passes in order through an input register, four curve
//   stages (scale product, exponent multiply, table interpolation, final scaling) and
//   three mixing stages (curvature product, reciprocal multiply by 1/127, correction
//   and sum). Throughput is one sample per cycle while the receiver takes every beat.
//   Every stage has its own valid bit and loads whenever the stage after it can take its
//   beat, so bubbles close up while the receiver stalls and in_tready drops only once the
//   whole pipe is full. Nothing is dropped or repeated.
//   Reset clears all valid bits and loads the default configuration: arcade mode,
//   throttle sign +1, both curves off.
module joystick_drive_mixer_expo_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_stick_x, left_stick_y, right_stick_x, right_stick_y (8 bits each)
  input  logic [jdme_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // left_velocity (13), right_velocity (13), zero pad (6)
  output logic [jdme_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [jdme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jdme_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NSTG = 8;

  jdme_pkg::drive_mode_t                 mode_r;
  logic signed [1:0]                     sign_r;
  logic [jdme_pkg::SCALE_W-1:0]          thr_curve_r;
  logic [jdme_pkg::SCALE_W-1:0]          turn_curve_r;
  logic [jdme_pkg::SCALE_W-1:0]          curve_wr;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;
  logic [NSTG-1:0] up_vld;

  logic signed [7:0] lx, ly, rx, ry;
  logic signed [7:0] thr_src, thr_x, turn_x;
  logic signed [7:0] thr_x_r, turn_x_r;

  logic signed [jdme_pkg::SHAPED_W-1:0] t_sh, u_sh;

  logic [10:0] at_m, au_m;
  logic signed [jdme_pkg::SHAPED_W-1:0] t1_r, u1_r;
  logic [21:0] p1_r;

  logic [21:0] w_sum;
  logic [17:0] w_m;
  logic [36:0] q_prod;
  logic signed [jdme_pkg::SHAPED_W-1:0] t2_r, u2_r;
  logic [17:0] w2_r;
  logic [11:0] q2_r;

  logic [18:0] q127;
  logic [18:0] rem_m;
  logic [11:0] k_m;
  logic signed [jdme_pkg::SHAPED_W-1:0] ks_m;
  logic signed [jdme_pkg::VEL_W:0] l_sum, r_sum;
  logic signed [jdme_pkg::VEL_W-1:0] l_r, r_r;

  function automatic logic signed [7:0] clamp_stick(input logic [7:0] raw);
    return (raw == 8'h80) ? 8'sh81 : $signed(raw);
  endfunction

  function automatic logic signed [jdme_pkg::VEL_W-1:0] sat_vel(
    input logic signed [jdme_pkg::VEL_W:0] v
  );
    logic signed [jdme_pkg::VEL_W:0] c;
    if (v > jdme_pkg::OUT_LIMIT) c = jdme_pkg::OUT_LIMIT;
    else if (v < -jdme_pkg::OUT_LIMIT) c = -jdme_pkg::OUT_LIMIT;
    else c = v;
    return c[jdme_pkg::VEL_W-1:0];
  endfunction

  // configuration
  assign curve_wr = (cfg_data > jdme_pkg::CURVE_MAX) ? jdme_pkg::CURVE_MAX : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jdme_pkg::MODE_ARCADE;
      sign_r <= 2'sd1;
      thr_curve_r <= '0;
      turn_curve_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jdme_pkg::CFG_DRIVE_MODE: mode_r <= jdme_pkg::drive_mode_t'(cfg_data[1:0]);
        jdme_pkg::CFG_THROTTLE_SIGN: sign_r <= (cfg_data[1:0] == 2'b10) ? -2'sd1
                                                                        : $signed(cfg_data[1:0]);
        jdme_pkg::CFG_THROTTLE_CURVE: thr_curve_r <= curve_wr;
        jdme_pkg::CFG_TURN_CURVE: turn_curve_r <= curve_wr;
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when it is empty or its beat moves on
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    up_vld = {vld_r[NSTG-2:0], in_tvalid};
    ld = rdy & up_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) vld_r[i] <= up_vld[i];
      end
    end
  end

  assign in_tready = rdy[0];

  // stage 0: route sticks by mode
  always_comb begin
    lx = clamp_stick(in_tdata[7:0]);
    ly = clamp_stick(in_tdata[15:8]);
    rx = clamp_stick(in_tdata[23:16]);
    ry = clamp_stick(in_tdata[31:24]);
    thr_src = (mode_r == jdme_pkg::MODE_REV_ARCADE) ? ry : ly;
    case (sign_r)
      2'sd1: thr_x = thr_src;
      -2'sd1: thr_x = -thr_src;
      default: thr_x = '0;
    endcase
    case (mode_r)
      jdme_pkg::MODE_TANK: turn_x = ry;
      jdme_pkg::MODE_REV_ARCADE: turn_x = lx;
      default: turn_x = rx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      thr_x_r <= thr_x;
      turn_x_r <= turn_x;
    end
  end

  // stages 1-4: curves
  jdme_curve u_thr_curve (
    .clk   (clk),
    .ld    (ld[4:1]),
    .x_in  (thr_x_r),
    .scale (thr_curve_r),
    .y_out (t_sh)
  );

  jdme_curve u_turn_curve (
    .clk   (clk),
    .ld    (ld[4:1]),
    .x_in  (turn_x_r),
    .scale (turn_curve_r),
    .y_out (u_sh)
  );

  // stage 5: curvature product
  always_comb begin
    at_m = t_sh[11] ? 11'(-t_sh) : t_sh[10:0];
    au_m = u_sh[11] ? 11'(-u_sh) : u_sh[10:0];
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      t1_r <= t_sh;
      u1_r <= u_sh;
      p1_r <= 22'(at_m) * 22'(au_m);
    end
  end

  // stage 6: divide by 2032 as shift by 4 then reciprocal of 127
  always_comb begin
    w_sum = p1_r + 22'd1016;
    w_m = w_sum[21:4];
    q_prod = 37'(w_m) * 37'(jdme_pkg::RECIP_127);
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      t2_r <= t1_r;
      u2_r <= u1_r;
      w2_r <= w_m;
      q2_r <= q_prod[36:25];
    end
  end

  // stage 7: correct quotient, mix, saturate
  always_comb begin
    q127 = {q2_r, 7'b0} - 19'(q2_r);
    rem_m = 19'(w2_r) - q127;
    k_m = (rem_m >= 19'd127) ? q2_r + 12'd1 : q2_r;
    ks_m = u2_r[11] ? -$signed(k_m) : $signed(k_m);
    case (mode_r)
      jdme_pkg::MODE_TANK: begin
        l_sum = 14'(t2_r);
        r_sum = 14'(u2_r);
      end
      jdme_pkg::MODE_CURVATURE: begin
        if (t2_r == '0) begin
          l_sum = 14'(u2_r);
          r_sum = -14'(u2_r);
        end else begin
          l_sum = 14'(t2_r) + 14'(ks_m);
          r_sum = 14'(t2_r) - 14'(ks_m);
        end
      end
      default: begin
        l_sum = 14'(t2_r) + 14'(u2_r);
        r_sum = 14'(t2_r) - 14'(u2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      l_r <= sat_vel(l_sum);
      r_r <= sat_vel(r_sum);
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata = {6'b0, r_r, l_r};

endmodule

[rtl/jdme_curve.sv]
// Four-stage exponential stick curve: scale product, log2 exponent, table, final shift.
module jdme_curve (
  input  logic                                clk,
  input  logic [3:0]                          ld,
  input  logic signed [jdme_pkg::STICK_W-1:0] x_in,
  input  logic [jdme_pkg::SCALE_W-1:0]        scale,
  output logic signed [jdme_pkg::SHAPED_W-1:0] y_out
);

  logic [7:0]  neg_x;
  logic [6:0]  mag_a;
  logic [6:0]  dist_a;
  logic [15:0] sd_a;

  logic        neg_a_r;
  logic [6:0]  mag_a_r;
  logic [15:0] sd_a_r;

  logic [31:0] e_full;
  logic        neg_b_r;
  logic [6:0]  mag_b_r;
  logic [13:0] e_b_r;

  logic [3:0]  idx_c;
  logic [7:0]  rem_c;
  logic [15:0] hi_c;
  logic [15:0] lo_c;
  logic [15:0] diff_c;
  logic [19:0] corr_c;
  logic [15:0] v_c;
  logic        neg_c_r;
  logic [6:0]  mag_c_r;
  logic [1:0]  n_c_r;
  logic [15:0] v_c_r;

  logic [27:0] prod_d;
  logic [27:0] sum_d;
  logic [27:0] shr_d;
  logic [11:0] ymag_d;
  logic signed [jdme_pkg::SHAPED_W-1:0] y_r;

  always_comb begin
    neg_x = 8'(-x_in);
    mag_a = x_in[7] ? neg_x[6:0] : x_in[6:0];
    dist_a = 7'd127 - mag_a;
    sd_a = 16'(scale) * 16'(dist_a);
  end

  always_comb begin
    e_full = 32'(sd_a_r) * jdme_pkg::LOG2_K + 32'd32768;
  end

  always_comb begin
    idx_c = e_b_r[11:8];
    rem_c = e_b_r[7:0];
    hi_c = jdme_pkg::pow2_val({1'b0, idx_c});
    lo_c = jdme_pkg::pow2_val(5'({1'b0, idx_c}) + 5'd1);
    diff_c = hi_c - lo_c;
    corr_c = 20'(diff_c) * 20'(rem_c) + 20'd128;
    v_c = hi_c - 16'(corr_c[19:8]);
  end

  always_comb begin
    prod_d = 28'({mag_c_r, 4'b0000}) * 28'(v_c_r);
    sum_d = prod_d + (28'd1 << (5'd14 + 5'(n_c_r)));
    shr_d = sum_d >> (5'd15 + 5'(n_c_r));
    ymag_d = {1'b0, shr_d[10:0]};
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      neg_a_r <= x_in[7];
      mag_a_r <= mag_a;
      sd_a_r <= sd_a;
    end
    if (ld[1]) begin
      neg_b_r <= neg_a_r;
      mag_b_r <= mag_a_r;
      e_b_r <= e_full[29:16];
    end
    if (ld[2]) begin
      neg_c_r <= neg_b_r;
      mag_c_r <= mag_b_r;
      n_c_r <= e_b_r[13:12];
      v_c_r <= v_c;
    end
    if (ld[3]) begin
      y_r <= neg_c_r ? -$signed(ymag_d) : $signed(ymag_d);
    end
  end

  assign y_out = y_r;

endmodule
